/* hw/rtl/iqed_pkg.sv */
// Shared types and constants for the I/Q energy detector with clear-channel assessment.
// Used by iqed_ctrl, iqed_dp and iq_energy_detector_cca_top; depends on nothing else.
`default_nettype none
package iqed_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int MAX_BLOCK    = 4096;
	localparam int COUNT_WIDTH  = 32;
	localparam int BLK_W        = 13;
	localparam int EST_W        = 48;
	localparam int CFG_ADDR_W   = 2;
	localparam int CFG_DATA_W   = 28;
	localparam int S_DATA_W     = 56;
	localparam int M_DATA_W     = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_ALPHA       = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_RATE = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE  = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_PROBE       = 2'd3;

	localparam logic [15:0] ALPHA_RESET = 16'd13107;
	localparam logic [19:0] US_PER_SEC  = 20'd1000000;
	// x / 1000000 is (x >> 6) / 15625; the divide by 15625 multiplies by
	// ceil(2^45 / 15625), which overshoots by at most one for a 42-bit dividend.
	localparam logic [31:0] RCP_M       = 32'd2251799814;
	localparam logic [31:0] DB_K        = 32'd197283;
	localparam logic [39:0] DB_OFS      = 40'((64'd1 << 23) - (64'd197283 << 20));
	localparam logic [15:0] DB_MIN      = 16'h8000;
	localparam logic [5:0]  MSB_POS     = 6'd47;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_PW_I,
		OP_PW_Q,
		OP_E0,
		OP_E1,
		OP_E2,
		OP_UPD,
		OP_NORM_INIT,
		OP_NORM,
		OP_SQR,
		OP_DBM,
		OP_OUT,
		OP_TMUL,
		OP_RCP_LO,
		OP_RCP_HI,
		OP_RCP_FIX,
		OP_TGT
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic [3:0] sq_bit;
	} dp_cmd_t;

	typedef struct packed {
		logic in_cmd;
		logic last;
		logic do_log;
		logic est_zero;
		logic norm_top;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/iqed_ctrl.sv */
// Controller of the energy detector: sequences the shared multiplier, the
// normalizer, the log squarer and the reciprocal divide. Depends on iqed_pkg.
`default_nettype none
module iqed_ctrl import iqed_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    s_tvalid,
	output logic         s_tready,
	output dp_cmd_t      cmd,
	input  wire dp_sts_t sts
);

	typedef enum logic [15:0] {
		ST_IDLE = 16'b0000000000000001,
		ST_PW_I = 16'b0000000000000010,
		ST_PW_Q = 16'b0000000000000100,
		ST_E0   = 16'b0000000000001000,
		ST_E1   = 16'b0000000000010000,
		ST_E2   = 16'b0000000000100000,
		ST_UPD  = 16'b0000000001000000,
		ST_LOGI = 16'b0000000010000000,
		ST_NORM = 16'b0000000100000000,
		ST_SQR  = 16'b0000001000000000,
		ST_DBM  = 16'b0000010000000000,
		ST_OUT  = 16'b0000100000000000,
		ST_TMUL = 16'b0001000000000000,
		ST_RLO  = 16'b0010000000000000,
		ST_RHI  = 16'b0100000000000000,
		ST_FIX  = 16'b1000000000000000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       tgt_q, tgt_d;

	assign s_tready = (state_q == ST_IDLE) && !tgt_q;

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		tgt_d      = 1'b0;
		cmd.op     = OP_NONE;
		cmd.sq_bit = 4'd15 - cnt_q;
		case (state_q)
			ST_IDLE: begin
				if (tgt_q) begin
					cmd.op = OP_TGT;
				end else if (s_tvalid) begin
					cmd.op  = OP_LOAD;
					state_d = sts.in_cmd ? ST_TMUL : ST_PW_I;
				end
			end
			ST_PW_I: begin
				cmd.op  = OP_PW_I;
				state_d = ST_PW_Q;
			end
			ST_PW_Q: begin
				cmd.op  = OP_PW_Q;
				state_d = ST_E0;
			end
			ST_E0: begin
				cmd.op  = OP_E0;
				state_d = ST_E1;
			end
			ST_E1: begin
				cmd.op  = OP_E1;
				state_d = ST_E2;
			end
			ST_E2: begin
				cmd.op  = OP_E2;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.op  = OP_UPD;
				state_d = sts.last ? ST_LOGI : ST_IDLE;
			end
			ST_LOGI: begin
				cmd.op  = OP_NORM_INIT;
				state_d = (!sts.do_log || sts.est_zero) ? ST_OUT : ST_NORM;
			end
			ST_NORM: begin
				cmd.op = OP_NORM;
				if (sts.norm_top) begin
					state_d = ST_SQR;
					cnt_d   = '0;
				end
			end
			ST_SQR: begin
				cmd.op = OP_SQR;
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q == 4'd15) begin
					state_d = ST_DBM;
				end
			end
			ST_DBM: begin
				cmd.op  = OP_DBM;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.op = OP_OUT;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_TMUL: begin
				cmd.op  = OP_TMUL;
				state_d = ST_RLO;
			end
			ST_RLO: begin
				cmd.op  = OP_RCP_LO;
				state_d = ST_RHI;
			end
			ST_RHI: begin
				cmd.op  = OP_RCP_HI;
				state_d = ST_FIX;
			end
			ST_FIX: begin
				cmd.op  = OP_RCP_FIX;
				state_d = ST_IDLE;
				tgt_d   = 1'b1;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			tgt_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			tgt_q   <= tgt_d;
		end
	end

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIX) |=> tgt_q && state_q == ST_IDLE)
		else $error("quotient correction did not hand over to the target update");
	a_sqr_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQR && cnt_q == 4'd15) |=> state_q == ST_DBM)
		else $error("log squaring did not end after sixteen steps");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && !sts.out_free) |=> state_q == ST_OUT && !s_tready)
		else $error("item taken while a result was stalled");

endmodule
`default_nettype wire

/* hw/rtl/iqed_dp.sv */
// Datapath of the energy detector: config registers, IIR estimate, CCA counters,
// shared 32x32 multiplier, normalizer, log squarer, reciprocal divide and output register.
// Depends on iqed_pkg.
`default_nettype none
module iqed_dp import iqed_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic [S_DATA_W-1:0]   s_tdata,
	input  wire logic                  s_tuser,
	input  wire logic                  s_tlast,
	input  wire logic                  m_tready,
	output logic                       m_tvalid,
	output logic [M_DATA_W-1:0]        m_tdata,
	output logic [1:0]                 m_tuser,
	input  wire dp_cmd_t               cmd,
	output dp_sts_t                    sts
);

	logic [15:0] alpha_q;
	logic [27:0] rate_q;
	logic [BLK_W-1:0] bsize_q;
	logic        probe_q;

	logic [15:0] i_q, q_q;
	logic [19:0] us_q;
	logic        last_q;

	logic [EST_W-1:0]       est_q;
	logic [BLK_W-1:0]       blk_q;
	logic                   active_q;
	logic [COUNT_WIDTH-1:0] ccnt_q, target_q;

	logic [31:0] pw_q;
	logic [63:0] acc_q;
	logic [EST_W-1:0] norm_q;
	logic [5:0]  pos_q;
	logic [15:0] frac_q;
	logic [15:0] db_q;
	logic [EST_W-1:0] qr_q;

	logic        out_valid_q;
	logic [15:0] out_db_q;
	logic        out_val_q, out_done_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic [16:0] i_mag, q_mag, one_m_alpha;
	logic signed [16:0] i_ext, q_ext;
	logic [63:0] acc_upd;
	logic [39:0] db_sum;
	logic [29:0] rcp_q0;
	logic [32:0] ccnt_sum;
	logic [COUNT_WIDTH-1:0] quot, tgt_new;
	logic        out_free;

	assign i_ext       = {i_q[15], i_q};
	assign q_ext       = {q_q[15], q_q};
	assign i_mag       = i_ext[16] ? 17'(-i_ext) : 17'(i_ext);
	assign q_mag       = q_ext[16] ? 17'(-q_ext) : 17'(q_ext);
	assign one_m_alpha = 17'h10000 - {1'b0, alpha_q};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_PW_I: begin
				mul_a = 32'(i_mag);
				mul_b = 32'(i_mag);
			end
			OP_PW_Q: begin
				mul_a = 32'(q_mag);
				mul_b = 32'(q_mag);
			end
			OP_E0: begin
				mul_a = 32'(one_m_alpha);
				mul_b = 32'(est_q[15:0]);
			end
			OP_E1: begin
				mul_a = 32'(one_m_alpha);
				mul_b = 32'(est_q[31:16]);
			end
			OP_E2: begin
				mul_a = 32'(one_m_alpha);
				mul_b = 32'(est_q[47:32]);
			end
			OP_UPD: begin
				mul_a = 32'(alpha_q);
				mul_b = pw_q;
			end
			OP_SQR: begin
				mul_a = norm_q[47:16];
				mul_b = norm_q[47:16];
			end
			OP_DBM: begin
				mul_a = 32'({pos_q, frac_q});
				mul_b = DB_K;
			end
			OP_TMUL: begin
				mul_a = 32'(us_q);
				mul_b = 32'(rate_q);
			end
			OP_RCP_LO: begin
				mul_a = qr_q[37:6];
				mul_b = RCP_M;
			end
			OP_RCP_HI: begin
				mul_a = 32'(qr_q[47:38]);
				mul_b = RCP_M;
			end
			OP_RCP_FIX: begin
				mul_a = 32'(rcp_q0);
				mul_b = 32'(US_PER_SEC);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod     = {32'd0, mul_a} * {32'd0, mul_b};
	assign acc_upd  = acc_q + {prod[47:0], 16'd0};
	assign db_sum   = prod[39:0] + DB_OFS;
	// Quotient estimate: the full product shifted down by 45 bits.
	assign rcp_q0   = acc_q[42:13];
	assign ccnt_sum = {1'b0, ccnt_q} + 33'(blk_q);
	assign quot     = (qr_q[47:32] != 16'd0) ? '1 : qr_q[31:0];
	assign tgt_new  = (quot < 32'(bsize_q)) ? 32'(bsize_q) : quot;
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
			rate_q  <= '0;
			bsize_q <= '0;
			probe_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ALPHA:       alpha_q <= cfg_wdata[15:0];
				REG_SAMPLE_RATE: rate_q  <= cfg_wdata[27:0];
				REG_BLOCK_SIZE:  bsize_q <= cfg_wdata[BLK_W-1:0];
				REG_PROBE:       probe_q <= cfg_wdata[0];
				default: begin
				end
			endcase
		end
	end

	// Architectural state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q       <= '0;
			blk_q       <= '0;
			active_q    <= 1'b0;
			ccnt_q      <= '0;
			target_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (cmd.op)
				OP_UPD: begin
					est_q <= acc_upd[63:16];
					if (blk_q < BLK_W'(MAX_BLOCK)) begin
						blk_q <= blk_q + BLK_W'(1);
					end
				end
				OP_TGT: begin
					target_q <= tgt_new;
					active_q <= 1'b1;
				end
				OP_OUT: begin
					if (out_free) begin
						est_q <= '0;
						blk_q <= '0;
						if (active_q) begin
							if (ccnt_q < target_q) begin
								ccnt_q <= ccnt_sum[32] ? '1 : ccnt_sum[31:0];
							end else begin
								active_q <= 1'b0;
								ccnt_q   <= '0;
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers; no reset needed.
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				i_q    <= s_tdata[15:0];
				q_q    <= s_tdata[31:16];
				us_q   <= s_tdata[51:32];
				last_q <= s_tlast;
			end
			OP_PW_I: pw_q  <= prod[31:0];
			OP_PW_Q: pw_q  <= pw_q + prod[31:0];
			OP_E0:   acc_q <= prod;
			OP_E1:   acc_q <= acc_q + {prod[47:0], 16'd0};
			OP_E2:   acc_q <= acc_q + {prod[31:0], 32'd0};
			OP_NORM_INIT: begin
				norm_q <= est_q;
				pos_q  <= MSB_POS;
				frac_q <= '0;
				db_q   <= (probe_q || active_q) ? DB_MIN : 16'd0;
			end
			OP_NORM: begin
				if (!norm_q[47]) begin
					norm_q <= {norm_q[46:0], 1'b0};
					pos_q  <= pos_q - 6'd1;
				end
			end
			OP_SQR: begin
				// The mantissa stays Q1.31; a square of two or more yields a log bit.
				if (prod[63]) begin
					norm_q[47:16]      <= prod[63:32];
					frac_q[cmd.sq_bit] <= 1'b1;
				end else begin
					norm_q[47:16] <= prod[62:31];
				end
			end
			OP_DBM: db_q <= db_sum[39:24];
			OP_TMUL: qr_q <= prod[47:0];
			OP_RCP_LO: acc_q <= prod;
			OP_RCP_HI: acc_q <= prod + {32'd0, acc_q[63:32]};
			OP_RCP_FIX: begin
				// The estimate is exact or one too large.
				qr_q <= (prod > 64'(qr_q)) ? 48'(rcp_q0) - 48'd1 : 48'(rcp_q0);
			end
			OP_OUT: begin
				if (out_free) begin
					out_db_q   <= db_q;
					out_val_q  <= active_q && (ccnt_q < target_q);
					out_done_q <= active_q && !(ccnt_q < target_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_db_q;
	assign m_tuser  = {out_done_q, out_val_q};

	assign sts.in_cmd   = s_tuser;
	assign sts.last     = last_q;
	assign sts.do_log   = probe_q || active_q;
	assign sts.est_zero = (est_q == '0);
	assign sts.norm_top = norm_q[47];
	assign sts.out_free = out_free;

	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("result tagged both as CCA value and as CCA done");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT && out_free && active_q && !(ccnt_q < target_q))
		|=> !active_q && ccnt_q == '0)
		else $error("CCA done block did not end the measurement");
	a_est_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_OUT && out_free) |=> est_q == '0 && blk_q == '0)
		else $error("block state not cleared after a result");

endmodule
`default_nettype wire

/* hw/rtl/iq_energy_detector_cca_top.sv */
// Sample item: two squares, three partial products of the IIR update and the update, all on
// one shared 32x32 multiplier; the next item is accepted after the update.
// Block-ending sample: after the update, a leading-one shift, 16 log squarings and dB scaling,
// or no log at all; the result then waits while an earlier one is not yet taken, and the
// next accept follows. CCA request: product, divide by 10^6, correction. One item at a time.
// Reset (arst_n low, asynchronous) clears estimate, counters, CCA state; config to defaults.
`default_nettype none
module iq_energy_detector_cca_top import iqed_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_DATA_W-1:0]   s_tdata,  // i_sample, q_sample, cca_time_us, zero pad
	input  wire logic                  s_tuser,  // command
	input  wire logic                  s_tlast,  // last_sample
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [M_DATA_W-1:0]        m_tdata,  // energy_db
	output logic [1:0]                 m_tuser   // cca_value, cca_done
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	iqed_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	iqed_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire
